@@ hdl/slt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table package
// Shared sizes, operation and status codes, and the structs that pass
// between the sequencer and the top level.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int DEPTH       = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int OUT_W       = 5;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic                   we;
      logic [ADDR_W-1:0]      waddr;
      logic [VALUE_WIDTH-1:0] wdata;
      logic [ADDR_W-1:0]      raddr;
   } mem_req_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [OUT_W-1:0]    position;
      logic [OUT_W-1:0]    match_count;
      logic [OUT_W-1:0]    fill_level;
   } rsp_type;

endpackage

@@ hdl/slt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module slt_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/slt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table sequencer
// Walks the table memory one entry per read/evaluate pair, shifting entries
// for insert and delete, and produces one result per transaction.
// ----------------------------------------------------------------------------
module slt_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [slt_pkg::KIND_W-1:0]       req_kind,
   input  logic [slt_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                             busy,
   output slt_pkg::mem_req_type             mem_req,
   input  logic [slt_pkg::VALUE_WIDTH-1:0]  rd_data,
   output slt_pkg::rsp_type                 rsp
);

   localparam int CntW  = slt_pkg::CNT_W;
   localparam int AddrW = slt_pkg::ADDR_W;
   localparam int OutW  = slt_pkg::OUT_W;
   localparam int ValW  = slt_pkg::VALUE_WIDTH;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [slt_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [ValW-1:0]             key_ff, key_in;
   logic [CntW-1:0]             idx_ff, idx_in;
   logic [CntW-1:0]             first_ff, first_in;
   logic [CntW-1:0]             hits_ff, hits_in;
   logic                        shift_ff, shift_in;
   logic [CntW-1:0]             count_ff, count_in;

   logic [CntW-1:0]             idx_inc;
   logic [CntW-1:0]             idx_dec;
   logic [CntW-1:0]             first_inc;
   logic [ValW-1:0]             req_key;
   logic                        done;
   logic [slt_pkg::STATUS_W-1:0] done_status;
   logic [CntW-1:0]             done_pos;
   logic [CntW-1:0]             done_hits;

   // Entries are stored as order keys: the sign bit is flipped so that an
   // unsigned compare gives signed order.
   assign req_key   = {~req_value[ValW-1], req_value[ValW-2:0]};
   assign idx_inc   = idx_ff + CntW'(1);
   assign idx_dec   = idx_ff - CntW'(1);
   assign first_inc = first_ff + CntW'(1);

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      hits_in     = hits_ff;
      shift_in    = shift_ff;
      count_in    = count_ff;
      mem_req     = '0;
      mem_req.wdata = key_ff;
      done        = 1'b0;
      done_status = slt_pkg::ST_DONE;
      done_pos    = '0;
      done_hits   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               key_in   = req_key;
               hits_in  = '0;
               shift_in = 1'b0;
               idx_in   = (req_kind == slt_pkg::KIND_INSERT) ? count_ff : '0;
               if (req_kind == slt_pkg::KIND_NONE) begin
                  done = 1'b1;
               end else if (req_kind == slt_pkg::KIND_INSERT &&
                            count_ff == CntW'(slt_pkg::DEPTH)) begin
                  done        = 1'b1;
                  done_status = slt_pkg::ST_FULL;
               end else begin
                  state_in = S_READ;
               end
            end
         end

         S_READ: begin
            case (kind_ff)
               slt_pkg::KIND_INSERT: begin
                  // The hole has moved down to the head: the key goes there.
                  if (idx_ff == '0) begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = '0;
                     count_in      = count_ff + CntW'(1);
                     done          = 1'b1;
                     done_pos      = CntW'(1);
                     state_in      = S_IDLE;
                  end else begin
                     mem_req.raddr = idx_dec[AddrW-1:0];
                     state_in      = S_EVAL;
                  end
               end
               slt_pkg::KIND_FIND: begin
                  if (idx_ff == count_ff) begin
                     done      = 1'b1;
                     state_in  = S_IDLE;
                     if (hits_ff == '0) begin
                        done_status = slt_pkg::ST_NOT_FOUND;
                     end else begin
                        done_pos  = first_inc;
                        done_hits = hits_ff;
                     end
                  end else begin
                     mem_req.raddr = idx_ff[AddrW-1:0];
                     state_in      = S_EVAL;
                  end
               end
               default: begin
                  if (!shift_ff) begin
                     if (idx_ff == count_ff) begin
                        done        = 1'b1;
                        done_status = slt_pkg::ST_NOT_FOUND;
                        state_in    = S_IDLE;
                     end else begin
                        mem_req.raddr = idx_ff[AddrW-1:0];
                        state_in      = S_EVAL;
                     end
                  end else if (idx_inc == count_ff) begin
                     count_in = count_ff - CntW'(1);
                     done     = 1'b1;
                     done_pos = first_inc;
                     state_in = S_IDLE;
                  end else begin
                     mem_req.raddr = idx_inc[AddrW-1:0];
                     state_in      = S_EVAL;
                  end
               end
            endcase
         end

         S_EVAL: begin
            state_in = S_READ;
            case (kind_ff)
               slt_pkg::KIND_INSERT: begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = idx_ff[AddrW-1:0];
                  if (rd_data >= key_ff) begin
                     mem_req.wdata = rd_data;
                     idx_in        = idx_dec;
                  end else begin
                     count_in = count_ff + CntW'(1);
                     done     = 1'b1;
                     done_pos = idx_inc;
                     state_in = S_IDLE;
                  end
               end
               slt_pkg::KIND_FIND: begin
                  if (rd_data == key_ff) begin
                     if (hits_ff == '0) begin
                        first_in = idx_ff;
                     end
                     hits_in = hits_ff + CntW'(1);
                     idx_in  = idx_inc;
                  end else if (rd_data < key_ff) begin
                     idx_in = idx_inc;
                  end else begin
                     done     = 1'b1;
                     state_in = S_IDLE;
                     if (hits_ff == '0) begin
                        done_status = slt_pkg::ST_NOT_FOUND;
                     end else begin
                        done_pos  = first_inc;
                        done_hits = hits_ff;
                     end
                  end
               end
               default: begin
                  if (shift_ff) begin
                     // Close the gap: entry idx+1 moves down to idx.
                     mem_req.we    = 1'b1;
                     mem_req.waddr = idx_ff[AddrW-1:0];
                     mem_req.wdata = rd_data;
                     idx_in        = idx_inc;
                  end else if (rd_data < key_ff) begin
                     idx_in = idx_inc;
                  end else if (rd_data == key_ff) begin
                     first_in = idx_ff;
                     shift_in = 1'b1;
                  end else begin
                     done        = 1'b1;
                     done_status = slt_pkg::ST_NOT_FOUND;
                     state_in    = S_IDLE;
                  end
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp.valid       = done;
      rsp.status      = done_status;
      rsp.position    = OutW'(done_pos);
      rsp.match_count = OutW'(done_hits);
      rsp.fill_level  = OutW'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      idx_ff   <= idx_in;
      first_ff <= first_in;
      hits_ff  <= hits_in;
      shift_ff <= shift_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

@@ hdl/sorted_list_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table
// Bounded ascending multiset of signed values with insert, find and delete.
// ----------------------------------------------------------------------------
// An insert into a full table or an unused kind is answered from the idle state,
// its result strobe registered in the cycle after start; otherwise the walk reads
// and then evaluates each visited entry, ending in a read when it runs off an end.
// One transaction at a time, busy high during the walk; for each entry it visits,
// the single table memory is read and the entry is then evaluated or written.
// Reset clears the entry count and the sequencer, not the table; no output stall.
module sorted_list_table_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [slt_pkg::KIND_W-1:0]           req_kind,
   input  logic signed [slt_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                 rsp_valid,
   output logic [slt_pkg::STATUS_W-1:0]         rsp_status,
   output logic [slt_pkg::OUT_W-1:0]            rsp_position,
   output logic [slt_pkg::OUT_W-1:0]            rsp_match_count,
   output logic [slt_pkg::OUT_W-1:0]            rsp_fill_level
);

   slt_pkg::mem_req_type                mem_req;
   slt_pkg::rsp_type                    rsp;
   logic [slt_pkg::VALUE_WIDTH-1:0]     rd_data;

   logic                                rsp_valid_ff;
   logic [slt_pkg::STATUS_W-1:0]        rsp_status_ff;
   logic [slt_pkg::OUT_W-1:0]           rsp_position_ff;
   logic [slt_pkg::OUT_W-1:0]           rsp_match_count_ff;
   logic [slt_pkg::OUT_W-1:0]           rsp_fill_level_ff;

   slt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .req_value (req_value),
      .busy      (busy),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .rsp       (rsp)
   );

   slt_ram #(
      .DEPTH (slt_pkg::DEPTH),
      .WIDTH (slt_pkg::VALUE_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (rd_data)
   );

   // Output register: each result transaction is shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp.valid;
      end
      rsp_status_ff      <= rsp.status;
      rsp_position_ff    <= rsp.position;
      rsp_match_count_ff <= rsp.match_count;
      rsp_fill_level_ff  <= rsp.fill_level;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_match_count = rsp_match_count_ff;
   assign rsp_fill_level  = rsp_fill_level_ff;

   // A walk always ends with a result in the cycle that busy falls.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result");

   // An unused kind is answered at once.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == slt_pkg::KIND_NONE) |=> (rsp_valid && !busy))
      else $error("unused kind not answered in one cycle");

   // A full-table refusal reports a full table and no position.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == slt_pkg::ST_FULL) |->
         (rsp_fill_level == slt_pkg::OUT_W'(slt_pkg::DEPTH) && rsp_position == '0))
      else $error("full status with wrong fill level or position");

   // A not-found result carries no position and no match count.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == slt_pkg::ST_NOT_FOUND) |->
         (rsp_position == '0 && rsp_match_count == '0))
      else $error("not-found result with position or matches");

endmodule

@@ verif/sorted_list_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table checker
// Watches the request and result channels of the sorted list table. It keeps
// a shadow copy of the ascending table, works out the result of every
// accepted request, and compares each result strobe with the oldest
// outstanding prediction. It reports the mismatch count and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module sorted_list_table_checker
   import slt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic [KIND_W-1:0]             req_kind,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          rsp_valid,
   input  logic [STATUS_W-1:0]           rsp_status,
   input  logic [OUT_W-1:0]              rsp_position,
   input  logic [OUT_W-1:0]              rsp_match_count,
   input  logic [OUT_W-1:0]              rsp_fill_level,
   output int                            error_count,
   output int                            pending_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OUT_W-1:0]    position;
      logic [OUT_W-1:0]    match_count;
      logic [OUT_W-1:0]    fill_level;
   } table_result_t;

   logic signed [VALUE_WIDTH-1:0] shadow_vals [DEPTH];
   int unsigned                   shadow_count;
   table_result_t                 due_results [$];
   table_result_t                 got;
   table_result_t                 want;

   // Applies one request to the shadow table and returns its result.
   task automatic apply_table_op(input  logic [KIND_W-1:0]             kind,
                                 input  logic signed [VALUE_WIDTH-1:0] value,
                                 output table_result_t                 res);
      int unsigned at;
      int unsigned n;
      int unsigned i;
      res = '0;
      at  = 0;
      n   = 0;
      // First slot whose entry is not smaller than the value.
      while (at < shadow_count && shadow_vals[at] < value)
         at++;
      case (kind)
         KIND_INSERT: begin
            if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (i = shadow_count; i > at; i--)
                  shadow_vals[i] = shadow_vals[i - 1];
               shadow_vals[at] = value;
               shadow_count++;
               res.position = OUT_W'(at + 1);
            end
         end
         KIND_FIND: begin
            while (at + n < shadow_count && shadow_vals[at + n] == value)
               n++;
            if (n == 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               res.position    = OUT_W'(at + 1);
               res.match_count = OUT_W'(n);
            end
         end
         KIND_DELETE: begin
            if (at < shadow_count && shadow_vals[at] == value) begin
               for (i = at; i + 1 < shadow_count; i++)
                  shadow_vals[i] = shadow_vals[i + 1];
               shadow_count--;
               res.position = OUT_W'(at + 1);
            end else begin
               res.status = ST_NOT_FOUND;
            end
         end
         default: begin
            // An unused kind leaves the table alone.
         end
      endcase
      res.fill_level = OUT_W'(shadow_count);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         due_results.delete();
      end else begin
         // A result at this edge always belongs to an earlier transaction,
         // so it is matched before the request of this edge is predicted.
         if (rsp_valid) begin
            got = '{rsp_status, rsp_position, rsp_match_count, rsp_fill_level};
            if (due_results.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result: status %0d position %0d count %0d fill %0d",
                           got.status, got.position, got.match_count, got.fill_level);
               error_count++;
            end else begin
               want = due_results.pop_front();
               if (got != want) begin
                  if (error_count < 10)
                     $display({"mismatch: status %0d/%0d position %0d/%0d ",
                               "count %0d/%0d fill %0d/%0d (actual/expected)"},
                              got.status, want.status, got.position, want.position,
                              got.match_count, want.match_count,
                              got.fill_level, want.fill_level);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            apply_table_op(req_kind, req_value, want);
            due_results.push_back(want);
         end
      end
      pending_count = due_results.size();
   end

endmodule

@@ verif/sorted_list_table_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list table testbench
// Drives insert, find and delete transactions into the sorted list table:
// a directed opening over the value extremes, empty and full tables, head and
// tail deletes and a table of sixteen equal entries, then random phases that
// fill, drain or churn the table. A checker beside the block predicts and
// compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module sorted_list_table_top_test;
   import slt_pkg::*;

   localparam int RANDOM_OPS   = 1500;
   localparam int PHASE_LEN    = 100;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 4;

   logic                          clock     = 1'b0;
   logic                          reset     = 1'b1;
   logic                          start     = 1'b0;
   logic [KIND_W-1:0]             req_kind  = KIND_INSERT;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          busy;
   logic                          rsp_valid;
   logic [STATUS_W-1:0]           rsp_status;
   logic [OUT_W-1:0]              rsp_position;
   logic [OUT_W-1:0]              rsp_match_count;
   logic [OUT_W-1:0]              rsp_fill_level;
   int                            error_count;
   int                            pending_count;
   int                            cycles = 0;

   always #5 clock = ~clock;

   sorted_list_table_top u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_match_count (rsp_match_count),
      .rsp_fill_level  (rsp_fill_level)
   );

   sorted_list_table_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_match_count (rsp_match_count),
      .rsp_fill_level  (rsp_fill_level),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly back to back, sometimes a few idle cycles, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // A narrow pool of small values gives duplicates and find/delete hits.
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      int r;
      int v;
      r = $urandom_range(99);
      if (r < 55) begin
         v = $urandom_range(8);
         return v - 4;
      end
      if (r < 70) begin
         case ($urandom_range(3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh7ffffffe;
            default: return 32'sh80000001;
         endcase
      end
      return $urandom();
   endfunction

   // Holds start until the transaction is taken, then idles for the requested gap.
   task automatic send_op(input logic [KIND_W-1:0]             kind,
                          input logic signed [VALUE_WIDTH-1:0] value,
                          input int                            gap);
      @(negedge clock);
      start     <= 1'b1;
      req_kind  <= kind;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drops start and waits until every outstanding result has come back.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int mode;
      int r;
      logic [KIND_W-1:0] kind;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table, unused kind, value extremes, head and tail deletes.
      send_op(KIND_FIND,   32'sh0,        pick_gap());
      send_op(KIND_DELETE, 32'sh0,        pick_gap());
      send_op(KIND_NONE,   32'shffffffff, pick_gap());
      send_op(KIND_INSERT, 32'sh7fffffff, pick_gap());
      send_op(KIND_INSERT, 32'sh80000000, pick_gap());
      send_op(KIND_INSERT, 32'sh0,        pick_gap());
      send_op(KIND_INSERT, 32'sh0,        pick_gap());
      send_op(KIND_FIND,   32'sh0,        pick_gap());
      send_op(KIND_DELETE, 32'sh80000000, pick_gap());
      send_op(KIND_FIND,   32'sh80000000, pick_gap());
      send_op(KIND_DELETE, 32'sh7fffffff, pick_gap());
      // Sixteen equal entries, then an insert into the full table.
      repeat (14) send_op(KIND_INSERT, 32'sh0, pick_gap());
      send_op(KIND_INSERT, 32'shffffffff, pick_gap());
      send_op(KIND_FIND,   32'sh0,        pick_gap());
      wait_idle();

      // Random phases: fill, drain or churn the table.
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % PHASE_LEN == 0) begin
            mode = $urandom_range(2);
            if (n == 7 * PHASE_LEN || $urandom_range(2) == 0)
               wait_idle();
         end
         r = $urandom_range(99);
         case (mode)
            0:       kind = (r < 70) ? KIND_INSERT : (r < 85) ? KIND_FIND :
                            (r < 97) ? KIND_DELETE : KIND_NONE;
            1:       kind = (r < 15) ? KIND_INSERT : (r < 30) ? KIND_FIND :
                            (r < 97) ? KIND_DELETE : KIND_NONE;
            default: kind = (r < 35) ? KIND_INSERT : (r < 65) ? KIND_FIND :
                            (r < 97) ? KIND_DELETE : KIND_NONE;
         endcase
         send_op(kind, pick_value(), pick_gap());
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/slt_pkg.sv
hdl/slt_ram.sv
hdl/slt_ctrl.sv
hdl/sorted_list_table_top.sv
verif/sorted_list_table_checker.sv
verif/sorted_list_table_top_test.sv
